// ===== hdl/lfa_pkg.sv =====
package lfa_pkg;

    localparam int WORD_W       = 32;
    localparam int WORD_SH      = 5;
    localparam int ID_COUNT_DEF = 1024;
    localparam int IDENT_W      = 10;

    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_ALLOCATE = 2'd1;
    localparam logic [1:0] KIND_FREE     = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_SCAN,
        ST_SET,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 found;
        logic [WORD_SH-1:0]   pos;
    } scan_res_t;

endpackage

// ===== hdl/lfa_word_scan.sv =====
module lfa_word_scan (
    input  logic [lfa_pkg::WORD_W-1:0] word,
    input  logic [lfa_pkg::WORD_W-1:0] used_mask,
    output lfa_pkg::scan_res_t         res
);

    logic [lfa_pkg::WORD_W-1:0] free_bits;

    assign free_bits = ~word & ~used_mask;

    // Lowest clear bit wins, so the loop runs from the top down.
    always_comb
    begin
        res.found = |free_bits;
        res.pos   = '0;
        for (int i = lfa_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                res.pos = lfa_pkg::WORD_SH'(i);
            end
        end
    end

endmodule

// ===== hdl/lowest_free_id_allocator_top.sv =====
// From the input transfer to the result register, register and free pass through MODIFY and
// DONE; an unknown kind, an identifier beyond the map or a hint at the top go straight to DONE;
// allocate scans the 32-bit bitmap words and passes through SET when a free identifier is found.
// One request at a time: the next is taken the cycle after the result loads, and a result
// that is not taken holds the block meanwhile.
// Reset clears the bitmap word by word before the first request is taken; hint resets to one.
module lowest_free_id_allocator_top #(
    parameter int ID_COUNT = lfa_pkg::ID_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [lfa_pkg::IDENT_W-1:0] ident,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lfa_pkg::IDENT_W-1:0] granted_ident,
    output logic                        status
);

    localparam int NW       = (ID_COUNT + lfa_pkg::WORD_W - 1) / lfa_pkg::WORD_W;
    localparam int AW       = (NW > 1) ? $clog2(NW) : 1;
    localparam int XW       = AW + lfa_pkg::WORD_SH;
    localparam int IDW      = $clog2(ID_COUNT);
    localparam int IW       = (XW > lfa_pkg::IDENT_W) ? XW : lfa_pkg::IDENT_W;
    localparam int LASTBITS = ID_COUNT - (NW - 1) * lfa_pkg::WORD_W;
    localparam logic [lfa_pkg::WORD_W-1:0] HI_MASK =
        (LASTBITS == lfa_pkg::WORD_W) ? '0 :
        ~((lfa_pkg::WORD_W'(1) << LASTBITS) - lfa_pkg::WORD_W'(1));

    logic [lfa_pkg::WORD_W-1:0] mem [NW];
    logic [lfa_pkg::WORD_W-1:0] rdata_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [AW-1:0]              mem_raddr;
    logic [lfa_pkg::WORD_W-1:0] mem_wdata;

    lfa_pkg::state_t    state_reg, state_next;
    logic [1:0]         kind_reg, kind_next;
    logic [IW-1:0]      ident_reg, ident_next;
    logic [IDW-1:0]     hint_reg, hint_next;
    logic [AW-1:0]      scan_w_reg, scan_w_next;
    logic               first_reg, first_next;
    logic [IDW-1:0]     new_hint_reg, new_hint_next;
    logic [IDW-1:0]     res_grant_reg, res_grant_next;
    logic               res_status_reg, res_status_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    logic [lfa_pkg::IDENT_W-1:0] out_grant_reg, out_grant_next;
    logic               out_status_reg, out_status_next;

    logic [XW-1:0]      hint_x;
    logic [XW-1:0]      start_x;
    logic [IW-1:0]      in_ident_x;
    logic [XW-1:0]      found_x;
    logic               in_ident_ok;
    logic               ident_below_hint;
    logic               alloc_exhausted;
    logic [lfa_pkg::WORD_W-1:0] ident_bit;
    logic [lfa_pkg::WORD_W-1:0] hint_bit;
    logic [lfa_pkg::WORD_W-1:0] scan_mask;
    logic [IW-1:0]      grant_x;
    lfa_pkg::scan_res_t scan_res;

    assign hint_x           = XW'(hint_reg);
    assign start_x          = hint_x + XW'(1);
    assign in_ident_x       = IW'(ident);
    assign in_ident_ok      = 32'(ident) < ID_COUNT;
    assign ident_below_hint = 32'(ident_reg) < 32'(hint_reg);
    assign alloc_exhausted  = (32'(hint_reg) + 32'd1) >= ID_COUNT;
    assign ident_bit        = lfa_pkg::WORD_W'(1) << ident_reg[lfa_pkg::WORD_SH-1:0];
    assign hint_bit         = lfa_pkg::WORD_W'(1) << hint_x[lfa_pkg::WORD_SH-1:0];
    assign found_x          = {scan_w_reg, scan_res.pos};
    assign grant_x          = IW'(res_grant_reg);

    // Bits below the start of the scan and beyond the last identifier count as used.
    always_comb
    begin
        scan_mask = '0;
        if (first_reg)
        begin
            scan_mask = (lfa_pkg::WORD_W'(1) << start_x[lfa_pkg::WORD_SH-1:0])
                        - lfa_pkg::WORD_W'(1);
        end
        if (scan_w_reg == AW'(NW - 1))
        begin
            scan_mask = scan_mask | HI_MASK;
        end
    end

    lfa_word_scan u_scan (
        .word      (rdata_reg),
        .used_mask (scan_mask),
        .res       (scan_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        ident_next      = ident_reg;
        hint_next       = hint_reg;
        scan_w_next     = scan_w_reg;
        first_next      = first_reg;
        new_hint_next   = new_hint_reg;
        res_grant_next  = res_grant_reg;
        res_status_next = res_status_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        out_grant_next  = out_grant_reg;
        out_status_next = out_status_reg;
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = ident_reg[XW-1:lfa_pkg::WORD_SH];
        mem_wdata       = rdata_reg;
        mem_raddr       = in_ident_x[XW-1:lfa_pkg::WORD_SH];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lfa_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(NW - 1))
                begin
                    state_next = lfa_pkg::ST_IDLE;
                end
            end
            lfa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (kind == lfa_pkg::KIND_ALLOCATE)
                begin
                    mem_raddr = start_x[XW-1:lfa_pkg::WORD_SH];
                end
                if (in_valid)
                begin
                    kind_next       = kind;
                    ident_next      = in_ident_x;
                    res_grant_next  = '0;
                    res_status_next = 1'b0;
                    scan_w_next     = start_x[XW-1:lfa_pkg::WORD_SH];
                    first_next      = 1'b1;
                    case (kind)
                        lfa_pkg::KIND_REGISTER, lfa_pkg::KIND_FREE:
                        begin
                            state_next = in_ident_ok ? lfa_pkg::ST_MODIFY : lfa_pkg::ST_DONE;
                        end
                        lfa_pkg::KIND_ALLOCATE:
                        begin
                            if (alloc_exhausted)
                            begin
                                res_status_next = 1'b1;
                                state_next      = lfa_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = lfa_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = lfa_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lfa_pkg::ST_MODIFY:
            begin
                mem_we = 1'b1;
                if (kind_reg == lfa_pkg::KIND_FREE)
                begin
                    mem_wdata = rdata_reg & ~ident_bit;
                    if (ident_below_hint)
                    begin
                        hint_next = ident_reg[IDW-1:0];
                    end
                end
                else
                begin
                    mem_wdata = rdata_reg | ident_bit;
                end
                state_next = lfa_pkg::ST_DONE;
            end
            lfa_pkg::ST_SCAN:
            begin
                first_next = 1'b0;
                if (scan_res.found)
                begin
                    // Fetch the word holding the hint so that its bit can be set.
                    mem_raddr     = hint_x[XW-1:lfa_pkg::WORD_SH];
                    new_hint_next = found_x[IDW-1:0];
                    state_next    = lfa_pkg::ST_SET;
                end
                else if (scan_w_reg == AW'(NW - 1))
                begin
                    res_status_next = 1'b1;
                    state_next      = lfa_pkg::ST_DONE;
                end
                else
                begin
                    mem_raddr   = scan_w_reg + AW'(1);
                    scan_w_next = scan_w_reg + AW'(1);
                end
            end
            lfa_pkg::ST_SET:
            begin
                mem_we         = 1'b1;
                mem_waddr      = hint_x[XW-1:lfa_pkg::WORD_SH];
                mem_wdata      = rdata_reg | hint_bit;
                res_grant_next = hint_reg;
                hint_next      = new_hint_reg;
                state_next     = lfa_pkg::ST_DONE;
            end
            lfa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_grant_next  = grant_x[lfa_pkg::IDENT_W-1:0];
                    out_status_next = res_status_reg;
                    state_next      = lfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfa_pkg::ST_CLEAR;
            hint_reg      <= IDW'(1);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        ident_reg      <= ident_next;
        scan_w_reg     <= scan_w_next;
        new_hint_reg   <= new_hint_next;
        res_grant_reg  <= res_grant_next;
        res_status_reg <= res_status_next;
        out_grant_reg  <= out_grant_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid     = out_valid_reg;
    assign granted_ident = out_grant_reg;
    assign status        = out_status_reg;

endmodule
